// ===== rtl/msob_pkg.sv =====
// package for the mass-spring oscillator bank: types, codes, reset tables
`timescale 1ns / 1ps

package msob_pkg;

    localparam int NUM_OSC_DEF = 8;

    localparam logic [23:0] DAMPING_RST     = 24'd16777048;
    localparam logic [31:0] TIME_STEP_RST   = 32'd42950;
    localparam logic [30:0] STRIKE_VEL_RST  = 31'd196608000;
    localparam logic [23:0] OUTPUT_GAIN_RST = 24'd254201;

    localparam logic [1:0] REG_DAMPING     = 2'd0;
    localparam logic [1:0] REG_TIME_STEP   = 2'd1;
    localparam logic [1:0] REG_STRIKE_VEL  = 2'd2;
    localparam logic [1:0] REG_OUTPUT_GAIN = 2'd3;

    localparam logic [26:0] STIFF_BASE = 27'd20000;
    localparam logic [26:0] STIFF_STEP = 27'd5000;
    localparam logic [17:0] INV_MASS_HEAVY = 18'd262143;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [23:0] damping;
        logic [31:0] time_step;
        logic [30:0] strike_velocity;
        logic [23:0] output_gain;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DAMP,
        ST_FORCE,
        ST_IMLO,
        ST_IMHI,
        ST_ACC,
        ST_DTLO,
        ST_DTHI,
        ST_DVEL,
        ST_VEL,
        ST_STEP,
        ST_POS,
        ST_ABS,
        ST_GLO,
        ST_GHI,
        ST_SCALE,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STRIKE,
        OP_CLEAR,
        OP_LOAD,
        OP_DAMP,
        OP_FORCE,
        OP_IMLO,
        OP_IMHI,
        OP_ACC,
        OP_DTLO,
        OP_DTHI,
        OP_DVEL,
        OP_VEL,
        OP_STEP,
        OP_POS,
        OP_ABS,
        OP_GLO,
        OP_GHI,
        OP_SCALE,
        OP_DIV,
        OP_FIN
    } dp_op_t;

    function automatic logic [26:0] stiff_reset(input logic [6:0] i);
        return STIFF_BASE + 27'(STIFF_STEP * 27'(i));
    endfunction

    // round(655360 / (10 - i)) for i up to 7, pinned to full scale from 8 up
    function automatic logic [17:0] inv_mass(input logic [6:0] i);
        logic [17:0] val;
        case (i)
            7'd0:    val = 18'd65536;
            7'd1:    val = 18'd72818;
            7'd2:    val = 18'd81920;
            7'd3:    val = 18'd93623;
            7'd4:    val = 18'd109227;
            7'd5:    val = 18'd131072;
            7'd6:    val = 18'd163840;
            7'd7:    val = 18'd218453;
            default: val = INV_MASS_HEAVY;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/mass_spring_oscillator_bank_unit.sv =====
// top level of the mass-spring oscillator bank: configuration registers and core
//
//  channel   ports                                 transaction
//  ------    ------------------------------------  -----------------------------------
//  item in   start, busy, mode, stiffness          start high while busy low
//  result    done, sample, clipped                 done high for one cycle, no stall
//  config    cfg_we, cfg_index, cfg_data           cfg_we high, written at once
//
// a strike is absorbed in the cycle it is taken and never raises busy
// a tick keeps busy high while each oscillator in turn is loaded, damped, forced
// and stepped through the single 32x32 multiplier, then for the gain multiply,
// rounding and a reciprocal multiply for the divide by NUM_OSC; done is
// registered from the final step and is high in the first cycle busy is low
// reset clears the valid bits, so every oscillator reads its reset state at once
`timescale 1ns / 1ps

module mass_spring_oscillator_bank_unit #(
    parameter int NUM_OSC = msob_pkg::NUM_OSC_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [26:0]        stiffness,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] sample,
    output logic               clipped
);

    import msob_pkg::*;

    localparam int IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    cfg_t              cfg_reg, cfg_next;
    dp_op_t            op;
    logic [IDX_W-1:0]  idx;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DAMPING:     cfg_next.damping         = cfg_data[23:0];
                REG_TIME_STEP:   cfg_next.time_step       = cfg_data;
                REG_STRIKE_VEL:  cfg_next.strike_velocity = cfg_data[30:0];
                REG_OUTPUT_GAIN: cfg_next.output_gain     = cfg_data[23:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damping         <= DAMPING_RST;
            cfg_reg.time_step       <= TIME_STEP_RST;
            cfg_reg.strike_velocity <= STRIKE_VEL_RST;
            cfg_reg.output_gain     <= OUTPUT_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    msob_ctrl #(.NUM_OSC(NUM_OSC), .IDX_W(IDX_W)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .busy  (busy),
        .op    (op),
        .idx   (idx)
    );

    msob_dp #(.NUM_OSC(NUM_OSC), .IDX_W(IDX_W)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .idx       (idx),
        .cfg       (cfg_reg),
        .stiffness (stiffness),
        .sample    (sample),
        .clipped   (clipped),
        .done      (done)
    );

    a_strike_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode |=> !busy)
        else $error("strike left the unit busy");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> busy)
        else $error("tick did not start the update");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && clipped |-> (sample == SAMPLE_MAX) || (sample == SAMPLE_MIN))
        else $error("clipped sample not at a rail");

endmodule

// ===== rtl/msob_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module msob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/msob_ctrl.sv =====
// sequencer for the oscillator update, sample scaling and divide steps
`timescale 1ns / 1ps

module msob_ctrl #(
    parameter int NUM_OSC = msob_pkg::NUM_OSC_DEF,
    parameter int IDX_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    output logic                busy,
    output msob_pkg::dp_op_t    op,
    output logic [IDX_W-1:0]    idx
);

    import msob_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_OSC - 1);

    ctrl_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        op = OP_STRIKE;
                    end
                    else
                    begin
                        op         = OP_CLEAR;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                op         = OP_LOAD;
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                op         = OP_DAMP;
                state_next = ST_FORCE;
            end
            ST_FORCE:
            begin
                op         = OP_FORCE;
                state_next = ST_IMLO;
            end
            ST_IMLO:
            begin
                op         = OP_IMLO;
                state_next = ST_IMHI;
            end
            ST_IMHI:
            begin
                op         = OP_IMHI;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                op         = OP_ACC;
                state_next = ST_DTLO;
            end
            ST_DTLO:
            begin
                op         = OP_DTLO;
                state_next = ST_DTHI;
            end
            ST_DTHI:
            begin
                op         = OP_DTHI;
                state_next = ST_DVEL;
            end
            ST_DVEL:
            begin
                op         = OP_DVEL;
                state_next = ST_VEL;
            end
            ST_VEL:
            begin
                op         = OP_VEL;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                op         = OP_STEP;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                op = OP_POS;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_ABS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_ABS:
            begin
                op         = OP_ABS;
                state_next = ST_GLO;
            end
            ST_GLO:
            begin
                op         = OP_GLO;
                state_next = ST_GHI;
            end
            ST_GHI:
            begin
                op         = OP_GHI;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                op         = OP_SCALE;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                op         = OP_DIV;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                op         = OP_FIN;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign idx  = idx_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("oscillator index out of range");

endmodule

// ===== rtl/msob_dp.sv =====
// datapath: oscillator state rams, shared multiplier, sample scaling and divider
`timescale 1ns / 1ps

module msob_dp #(
    parameter int NUM_OSC = msob_pkg::NUM_OSC_DEF,
    parameter int IDX_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msob_pkg::dp_op_t      op,
    input  logic [IDX_W-1:0]      idx,
    input  msob_pkg::cfg_t        cfg,
    input  logic [26:0]           stiffness,
    output logic signed [15:0]    sample,
    output logic                  clipped,
    output logic                  done
);

    import msob_pkg::*;

    localparam int CLOG_N = $clog2(NUM_OSC);
    localparam int SUM_W  = 32 + CLOG_N;
    localparam int MAG_W  = SUM_W + 1;
    localparam int XW     = MAG_W + 25;
    localparam int YF_W   = XW - 24;
    localparam int Y_W    = 17 + CLOG_N;

    localparam logic [XW-1:0]    HALF_DIV = XW'(NUM_OSC) << 23;
    localparam logic [Y_W-1:0]   Y_MAX    = Y_W'(32769 * NUM_OSC);
    // floor(2^30 / NUM_OSC) + 1, exact quotient for every capped scaled value
    localparam logic [31:0]      RECIP    = 32'((64'd1 << 30) / NUM_OSC + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_OSC - 1);
    localparam logic [40:0]      DVEL_CAP = 41'h100_0000_0000;

    localparam logic signed [42:0] NV_MAX = 43'sd2147483647;
    localparam logic signed [42:0] NV_MIN = -43'sd2147483648;
    localparam logic signed [33:0] NP_MAX = 34'sd2147483647;
    localparam logic signed [33:0] NP_MIN = -34'sd2147483648;

    // control state
    logic [IDX_W-1:0]   slot_reg;
    logic [NUM_OSC-1:0] pos_vld_reg;
    logic [NUM_OSC-1:0] vel_vld_reg;
    logic [NUM_OSC-1:0] stf_vld_reg;
    logic               done_reg;

    // payload
    logic [63:0]               prod_reg;
    logic signed [31:0]        p_reg;
    logic [31:0]               pmag_reg;
    logic [31:0]               vmag_reg;
    logic                      v_neg_reg;
    logic [26:0]               k_reg;
    logic [17:0]               im_reg;
    logic [31:0]               dmag_reg;
    logic [26:0]               fhi_reg;
    logic [34:0]               t_reg;
    logic [61:0]               acc_reg;
    logic [40:0]               dvel_reg;
    logic [31:0]               v2mag_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [55:0]               lo_reg;
    logic [Y_W-1:0]            y_reg;
    logic signed [15:0]        sample_reg;
    logic                      clip_reg;

    // ram ports
    logic               vel_we, pos_we, stf_we;
    logic [IDX_W-1:0]   vel_waddr;
    logic [31:0]        vel_wdata;
    logic [31:0]        pos_rd, vel_rd;
    logic [26:0]        stf_rd;

    // combinational values
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             prod_next;
    logic signed [31:0]      ld_p, ld_v;
    logic [26:0]             ld_k;
    logic [63:0]             rnd24, rnd16;
    logic [64:0]             rnd32;
    logic [61:0]             acc_next;
    logic [62:0]             dvel_sum;
    logic [40:0]             dvel_next;
    logic signed [42:0]      nv_d, nv;
    logic signed [31:0]      v2;
    logic [32:0]             step;
    logic signed [33:0]      np;
    logic signed [31:0]      np_sat;
    logic signed [MAG_W-1:0] sum_ext;
    logic [XW-1:0]           scale_x;
    logic [YF_W-1:0]         scale_y;
    logic [Y_W-1:0]          scale_ys;
    logic [15:0]             qy;
    logic signed [15:0]      fin_sample;
    logic                    fin_clip;

    msob_ram #(.WIDTH(32), .DEPTH(NUM_OSC), .AW(IDX_W)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (idx),
        .wdata (np_sat),
        .raddr (idx),
        .rdata (pos_rd)
    );

    msob_ram #(.WIDTH(32), .DEPTH(NUM_OSC), .AW(IDX_W)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (vel_waddr),
        .wdata (vel_wdata),
        .raddr (idx),
        .rdata (vel_rd)
    );

    msob_ram #(.WIDTH(27), .DEPTH(NUM_OSC), .AW(IDX_W)) u_stf_ram (
        .clk   (clk),
        .we    (stf_we),
        .waddr (slot_reg),
        .wdata (stiffness),
        .raddr (idx),
        .rdata (stf_rd)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_DAMP:
            begin
                mul_a = vmag_reg;
                mul_b = {8'd0, cfg.damping};
            end
            OP_FORCE:
            begin
                mul_a = pmag_reg;
                mul_b = {5'd0, k_reg};
            end
            OP_IMLO:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {14'd0, im_reg};
            end
            OP_IMHI:
            begin
                mul_a = {5'd0, fhi_reg};
                mul_b = {14'd0, im_reg};
            end
            OP_DTLO:
            begin
                mul_a = acc_reg[31:0];
                mul_b = cfg.time_step;
            end
            OP_DTHI:
            begin
                mul_a = {2'd0, acc_reg[61:32]};
                mul_b = cfg.time_step;
            end
            OP_STEP:
            begin
                mul_a = v2mag_reg;
                mul_b = cfg.time_step;
            end
            OP_GLO:
            begin
                mul_a = mag_reg[31:0];
                mul_b = {8'd0, cfg.output_gain};
            end
            OP_GHI:
            begin
                mul_a = 32'(mag_reg[MAG_W-1:32]);
                mul_b = {8'd0, cfg.output_gain};
            end
            OP_DIV:
            begin
                mul_a = 32'(y_reg);
                mul_b = RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    // oscillator arithmetic
    always_comb
    begin
        ld_p = pos_vld_reg[idx] ? $signed(pos_rd) : 32'sd0;
        ld_v = vel_vld_reg[idx] ? $signed(vel_rd) : 32'sd0;
        ld_k = stf_vld_reg[idx] ? stf_rd : stiff_reset(7'(idx));

        rnd24 = prod_reg + 64'h80_0000;
        rnd16 = prod_reg + 64'h8000;
        rnd32 = {1'b0, prod_reg} + 65'h8000_0000;

        acc_next = 62'(t_reg) + {prod_reg[45:0], 16'd0};

        dvel_sum  = 63'(t_reg) + prod_reg[62:0];
        dvel_next = (dvel_sum > 63'(DVEL_CAP)) ? DVEL_CAP : dvel_sum[40:0];

        nv_d = v_neg_reg ? -$signed({11'd0, dmag_reg}) : $signed({11'd0, dmag_reg});
        if (p_reg > 32'sd0)
        begin
            nv = nv_d - $signed({2'd0, dvel_reg});
        end
        else if (p_reg < 32'sd0)
        begin
            nv = nv_d + $signed({2'd0, dvel_reg});
        end
        else
        begin
            nv = nv_d;
        end
        if (nv > NV_MAX)
        begin
            v2 = 32'sh7fff_ffff;
        end
        else if (nv < NV_MIN)
        begin
            v2 = 32'sh8000_0000;
        end
        else
        begin
            v2 = nv[31:0];
        end

        step = rnd32[64:32];
        if (v_neg_reg)
        begin
            np = 34'(p_reg) - $signed({1'b0, step});
        end
        else
        begin
            np = 34'(p_reg) + $signed({1'b0, step});
        end
        if (np > NP_MAX)
        begin
            np_sat = 32'sh7fff_ffff;
        end
        else if (np < NP_MIN)
        begin
            np_sat = 32'sh8000_0000;
        end
        else
        begin
            np_sat = np[31:0];
        end

        sum_ext = MAG_W'(sum_reg);

        scale_x  = XW'(lo_reg) + (XW'(prod_reg) << 32) + HALF_DIV;
        scale_y  = scale_x[XW-1:24];
        scale_ys = (scale_y > YF_W'(Y_MAX)) ? Y_MAX : scale_y[Y_W-1:0];

        qy = prod_reg[45:30];

        fin_clip   = 1'b0;
        fin_sample = $signed(qy);
        if (neg_reg)
        begin
            if (qy > 16'd32768)
            begin
                fin_sample = SAMPLE_MIN;
                fin_clip   = 1'b1;
            end
            else
            begin
                fin_sample = $signed(16'd0 - qy);
            end
        end
        else if (qy > 16'd32767)
        begin
            fin_sample = SAMPLE_MAX;
            fin_clip   = 1'b1;
        end
    end

    // velocity written by strike or by the update, position by the update
    always_comb
    begin
        vel_we    = (op == OP_STRIKE) || (op == OP_VEL);
        vel_waddr = (op == OP_STRIKE) ? slot_reg : idx;
        vel_wdata = (op == OP_STRIKE) ? {1'b0, cfg.strike_velocity} : v2;
        pos_we    = (op == OP_POS);
        stf_we    = (op == OP_STRIKE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            pos_vld_reg <= '0;
            vel_vld_reg <= '0;
            stf_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (op == OP_FIN);
            if (op == OP_STRIKE)
            begin
                vel_vld_reg[slot_reg] <= 1'b1;
                stf_vld_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == IDX_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (op == OP_VEL)
            begin
                vel_vld_reg[idx] <= 1'b1;
            end
            if (op == OP_POS)
            begin
                pos_vld_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (op)
            OP_CLEAR: sum_reg <= '0;
            OP_LOAD:
            begin
                p_reg     <= ld_p;
                pmag_reg  <= ld_p[31] ? (~ld_p + 32'd1) : ld_p;
                vmag_reg  <= ld_v[31] ? (~ld_v + 32'd1) : ld_v;
                v_neg_reg <= ld_v[31];
                k_reg     <= ld_k;
                im_reg    <= inv_mass(7'(idx));
            end
            OP_FORCE: dmag_reg <= rnd24[55:24];
            OP_IMLO:  fhi_reg <= prod_reg[58:32];
            OP_IMHI:  t_reg <= rnd16[50:16];
            OP_ACC:   acc_reg <= acc_next;
            OP_DTHI:  t_reg <= 35'(rnd32[64:32]);
            OP_DVEL:  dvel_reg <= dvel_next;
            OP_VEL:
            begin
                v2mag_reg <= v2[31] ? (~v2 + 32'd1) : v2;
                v_neg_reg <= v2[31];
            end
            OP_POS:   sum_reg <= sum_reg + SUM_W'(np_sat);
            OP_ABS:
            begin
                neg_reg <= sum_ext[MAG_W-1];
                mag_reg <= sum_ext[MAG_W-1] ? -sum_ext : sum_ext;
            end
            OP_GHI:   lo_reg <= prod_reg[55:0];
            OP_SCALE: y_reg <= scale_ys;
            OP_FIN:
            begin
                sample_reg <= fin_sample;
                clip_reg   <= fin_clip;
            end
            default: ;
        endcase
    end

    assign sample  = sample_reg;
    assign clipped = clip_reg;
    assign done    = done_reg;

endmodule

// ===== sim/msob_sample_checker.sv =====
// checker for the oscillator bank: mirrors oscillator state and compares each sample
`timescale 1ns / 1ps

module msob_sample_checker #(
    parameter int NUM_OSC = msob_pkg::NUM_OSC_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               is_strike,
    input  logic [26:0]        stiffness,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               done,
    input  logic signed [15:0] sample,
    input  logic               clipped,
    output int                 mismatches,
    output int                 samples_owed
);

    typedef struct packed {
        logic signed [15:0] level;
        logic               clip;
    } sample_t;

    sample_t expected_samples[$];

    logic [23:0] damping_r;
    logic [31:0] time_step_r;
    logic [30:0] strike_velocity_r;
    logic [23:0] gain_r;

    logic signed [31:0] position[NUM_OSC];
    logic signed [31:0] velocity[NUM_OSC];
    logic [26:0]        spring_k[NUM_OSC];
    logic [17:0]        inv_mass[NUM_OSC];
    int unsigned        next_slot;

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // rounded a*b >> s on the full product, pinned to all ones where it overflows
    function automatic logic [63:0] round_shift_product(input logic [63:0] a,
                                                        input logic [63:0] b,
                                                        input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return (p[127:64] != 64'd0) ? '1 : p[63:0];
    endfunction

    task automatic reset_model();
        damping_r         = msob_pkg::DAMPING_RST;
        time_step_r       = msob_pkg::TIME_STEP_RST;
        strike_velocity_r = msob_pkg::STRIKE_VEL_RST;
        gain_r            = msob_pkg::OUTPUT_GAIN_RST;
        for (int i = 0; i < NUM_OSC; i++)
        begin
            position[i] = '0;
            velocity[i] = '0;
            spring_k[i] = 27'(int'(msob_pkg::STIFF_BASE) + int'(msob_pkg::STIFF_STEP) * i);
            if (i <= 7)
                inv_mass[i] = 18'((1310720 + (10 - i)) / (2 * (10 - i)));
            else
                inv_mass[i] = msob_pkg::INV_MASS_HEAVY;
        end
        next_slot = 0;
        expected_samples.delete();
        mismatches = 0;
        samples_owed = 0;
    endtask

    task automatic apply_register_write(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            msob_pkg::REG_DAMPING:     damping_r = data[23:0];
            msob_pkg::REG_TIME_STEP:   time_step_r = data;
            msob_pkg::REG_STRIKE_VEL:  strike_velocity_r = data[30:0];
            msob_pkg::REG_OUTPUT_GAIN: gain_r = data[23:0];
            default: ;
        endcase
    endtask

    // one semi-implicit euler step of oscillator i
    task automatic step_oscillator(input int i);
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic signed [31:0] v2;
        logic [63:0]        dmag;
        logic [63:0]        acc;
        logic [63:0]        dvel;
        logic [63:0]        dpos;
        logic signed [63:0] nv;
        logic signed [63:0] np;
        p = position[i];
        v = velocity[i];
        dmag = (magnitude(v) * 64'(damping_r) + (64'd1 << 23)) >> 24;
        nv = (v < 0) ? -$signed(dmag) : $signed(dmag);
        acc = round_shift_product(magnitude(p) * 64'(spring_k[i]), 64'(inv_mass[i]), 16);
        dvel = round_shift_product(acc, 64'(time_step_r), 32);
        if (dvel > (64'd1 << 40))
            dvel = 64'd1 << 40;
        if (p > 0)
            nv = nv - $signed(dvel);
        else if (p < 0)
            nv = nv + $signed(dvel);
        v2 = clamp32(nv);
        velocity[i] = v2;
        dpos = (magnitude(v2) * 64'(time_step_r) + (64'd1 << 31)) >> 32;
        np = p;
        np = (v2 < 0) ? np - $signed(dpos) : np + $signed(dpos);
        position[i] = clamp32(np);
    endtask

    task automatic apply_item(input logic strike, input logic [26:0] k);
        int unsigned        slot;
        logic signed [63:0] total;
        logic [63:0]        scaled;
        logic [63:0]        divisor;
        logic [63:0]        q;
        sample_t            want;
        if (strike)
        begin
            slot = next_slot % NUM_OSC;
            spring_k[slot] = k;
            velocity[slot] = $signed({1'b0, strike_velocity_r});
            next_slot = (slot + 1) % NUM_OSC;
        end
        else
        begin
            total = '0;
            for (int i = 0; i < NUM_OSC; i++)
            begin
                step_oscillator(i);
                total = total + position[i];
            end
            scaled = magnitude(total) * 64'(gain_r);
            divisor = 64'(NUM_OSC) << 24;
            q = (scaled + divisor / 2) / divisor;
            want.clip = 1'b0;
            if (total < 0)
            begin
                if (q > 64'd32768)
                begin
                    want.level = msob_pkg::SAMPLE_MIN;
                    want.clip = 1'b1;
                end
                else
                begin
                    want.level = 16'(64'd0 - q);
                end
            end
            else if (q > 64'd32767)
            begin
                want.level = msob_pkg::SAMPLE_MAX;
                want.clip = 1'b1;
            end
            else
            begin
                want.level = q[15:0];
            end
            expected_samples.push_back(want);
        end
    endtask

    task automatic compare_sample(input logic signed [15:0] got_level, input logic got_clip);
        sample_t want;
        if (expected_samples.size() == 0)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("unexpected sample %0d clipped %0b at %0t", got_level, got_clip, $time);
        end
        else
        begin
            want = expected_samples.pop_front();
            if (got_level !== want.level || got_clip !== want.clip)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("sample %0d clipped %0b, expected %0d clipped %0b at %0t",
                             got_level, got_clip, want.level, want.clip, $time);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (done)
                compare_sample(sample, clipped);
            if (start && !busy)
                apply_item(is_strike, stiffness);
            if (cfg_we)
                apply_register_write(cfg_index, cfg_data);
            samples_owed = expected_samples.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// testbench top for the oscillator bank: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;

    localparam int NUM_OSC       = msob_pkg::NUM_OSC_DEF;
    localparam int TICK_CYCLES   = 13 * NUM_OSC + 6;
    localparam int SETTLE_CYCLES = TICK_CYCLES + 20;
    localparam int STALL_LIMIT   = 20 * TICK_CYCLES;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 12;
    localparam int CALM_ITEMS    = 200;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_STRIKE = 1'b1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode = MODE_TICK;
    logic [26:0]        stiffness = '0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = msob_pkg::REG_DAMPING;
    logic [31:0]        cfg_data = '0;
    logic               busy;
    logic               done;
    logic signed [15:0] sample;
    logic               clipped;
    int                 mismatches;
    int                 samples_owed;
    int                 stall_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mass_spring_oscillator_bank_unit #(
        .NUM_OSC(NUM_OSC)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .stiffness(stiffness),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .done     (done),
        .sample   (sample),
        .clipped  (clipped)
    );

    msob_sample_checker #(
        .NUM_OSC(NUM_OSC)
    ) sample_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .is_strike   (mode == MODE_STRIKE),
        .stiffness   (stiffness),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .sample      (sample),
        .clipped     (clipped),
        .mismatches  (mismatches),
        .samples_owed(samples_owed)
    );

    // cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("mass_spring_oscillator_bank_unit: mismatch");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic m, input logic [26:0] k);
        @(negedge clk);
        start <= 1'b1;
        mode <= m;
        stiffness <= k;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst(input bit after_busy);
        int n;
        n = $urandom_range(1, 9);
        @(negedge clk);
        start <= 1'b0;
        if (after_busy)
            while (busy)
                @(negedge clk);
        repeat (n - 1) @(negedge clk);
    endtask

    // hold off until every sample is back and the block has gone quiet
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (samples_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] damp, input logic [31:0] dt,
                                 input logic [31:0] vel, input logic [31:0] gain);
        write_reg(msob_pkg::REG_DAMPING, damp);
        write_reg(msob_pkg::REG_TIME_STEP, dt);
        write_reg(msob_pkg::REG_STRIKE_VEL, vel);
        write_reg(msob_pkg::REG_OUTPUT_GAIN, gain);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_setting(input logic [1:0] idx);
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = '0;
            1: v = '1;
            2: v = $urandom;
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        // keep most damping settings close to lossless so motion lasts
        if (idx == msob_pkg::REG_DAMPING && sel >= 4)
            v = {8'($urandom), 24'hffffff - 24'($urandom_range(0, 20000))};
        return v;
    endfunction

    function automatic logic [26:0] pick_stiffness();
        logic [26:0] k;
        case ($urandom_range(0, 7))
            0: k = '0;
            1: k = '1;
            2: k = 27'($urandom);
            3: k = 27'd100000000;
            default: k = 27'($urandom_range(1, 100000000) >> $urandom_range(0, 26));
        endcase
        return k;
    endfunction

    initial
    begin
        int   phase_len;
        int   idle_odds;
        int   sent;
        logic m;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: quiet bank, stiffness extremes, slot wrap
        send_item(MODE_TICK, '1);
        send_item(MODE_STRIKE, 27'd0);
        send_item(MODE_STRIKE, 27'd1);
        send_item(MODE_STRIKE, 27'd100000000);
        send_item(MODE_STRIKE, 27'h7ffffff);
        send_item(MODE_STRIKE, 27'h5555555);
        send_item(MODE_STRIKE, 27'h2aaaaaa);
        send_item(MODE_STRIKE, 27'd20000);
        send_item(MODE_STRIKE, 27'd65535);
        send_item(MODE_STRIKE, 27'd4242);
        repeat (4) send_item(MODE_TICK, 27'd0);

        // full scale settings drive the sample into both rails
        drain();
        load_settings('1, '1, '1, '1);
        send_item(MODE_STRIKE, 27'h7ffffff);
        repeat (5) send_item(MODE_TICK, 27'h2aaaaaa);
        drain();
        load_settings('0, '0, '0, '0);
        send_item(MODE_STRIKE, 27'd3000);
        send_item(MODE_TICK, 27'h5555555);

        sent = 0;
        phase_len = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            load_settings(pick_setting(msob_pkg::REG_DAMPING),
                          pick_setting(msob_pkg::REG_TIME_STEP),
                          pick_setting(msob_pkg::REG_STRIKE_VEL),
                          pick_setting(msob_pkg::REG_OUTPUT_GAIN));
            idle_odds = $urandom_range(0, 3);
            for (int n = 0; n < phase_len; n++)
            begin
                m = ($urandom_range(0, 9) < 3) ? MODE_STRIKE : MODE_TICK;
                send_item(m, pick_stiffness());
                sent++;
                if (sent < RANDOM_ITEMS - CALM_ITEMS)
                begin
                    if (idle_odds != 0 && $urandom_range(0, 3) < idle_odds)
                        idle_burst($urandom_range(0, 1));
                    if ($urandom_range(0, 99) == 0)
                        drain();
                end
            end
        end

        drain();
        if (mismatches == 0 && samples_owed == 0)
            $display("mass_spring_oscillator_bank_unit: match");
        else
            $display("mass_spring_oscillator_bank_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/msob_pkg.sv
rtl/msob_ram.sv
rtl/msob_ctrl.sv
rtl/msob_dp.sv
rtl/mass_spring_oscillator_bank_unit.sv
sim/msob_sample_checker.sv
sim/tb.sv
